// ===== hdl/psf_pkg.sv =====
// psf_pkg: shared types and constants for the scanline fill block.
// No dependencies.
package psf_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;
  localparam int MAX_SPANS = 8;
  localparam int COLOR_W   = 32;
  localparam int OUT_W     = 11;

  // control word broadcast to the edge cells
  typedef struct packed {
    logic clr;    // drop all edges
    logic load;   // shift a new edge in at the head
    logic enter;  // start of row: compute crossings
    logic step;   // one Bresenham step where still pending
  } cell_ctl_t;
endpackage

// ===== hdl/psf_edge_cell.sv =====
// psf_edge_cell: one polygon edge with its Bresenham walker.
// Depends on psf_pkg. Cells chain: load shifts edge data to the next cell.
module psf_edge_cell import psf_pkg::*; #(
  parameter int CW = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cell_ctl_t       ctl,
  input  logic [CW-1:0]   row,
  input  logic            prv_valid,
  input  logic [CW-1:0]   prv_tx,
  input  logic [CW-1:0]   prv_ty,
  input  logic [CW-1:0]   prv_bx,
  input  logic [CW-1:0]   prv_by,
  output logic            valid,
  output logic [CW-1:0]   tx,
  output logic [CW-1:0]   ty,
  output logic [CW-1:0]   bx,
  output logic [CW-1:0]   by,
  output logic            hit,
  output logic            busy,
  output logic [CW-1:0]   cur_x
);
  logic            valid_r;
  logic [CW-1:0]   tx_r, ty_r, bx_r, by_r, cx_r, cy_r, oldy_r;
  logic [CW+1:0]   err_r, err_nxt;
  logic            hit_r, hit_nxt, busy_r, busy_nxt;
  logic [CW-1:0]   cx_nxt, cy_nxt, oldy_nxt;
  logic [CW+1:0]   dx, dy;
  logic            left;

  assign left = bx_r < tx_r;
  assign dx   = left ? {2'b0, tx_r - bx_r} : {2'b0, bx_r - tx_r};
  assign dy   = {2'b0, ty_r - by_r};

  always_comb begin
    err_nxt  = err_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    hit_nxt  = hit_r;
    busy_nxt = busy_r;
    oldy_nxt = oldy_r;
    if (ctl.enter) begin
      hit_nxt  = 1'b0;
      busy_nxt = 1'b0;
      if (valid_r && row == ty_r) begin
        err_nxt = (dx > dy) ? (dx >> 1) : -(dy >> 1);
        cx_nxt  = tx_r;
        cy_nxt  = ty_r;
        hit_nxt = 1'b1;
      end else if (valid_r && row > by_r && row < ty_r) begin
        hit_nxt  = 1'b1;
        busy_nxt = 1'b1;
        oldy_nxt = cy_r;
      end
    end else if (ctl.step && busy_r) begin
      // y only descends; stop once it leaves the previous row
      if ($signed(err_r) > -$signed(dx)) begin
        err_nxt = err_r - dy;
        cx_nxt  = left ? cx_r - 1'b1 : cx_r + 1'b1;
      end
      if ($signed(err_r) < $signed(dy)) begin
        err_nxt = err_nxt + dx;
        cy_nxt  = cy_r - 1'b1;
      end
      if (cy_nxt != oldy_r) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= prv_valid;
      hit_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      hit_r   <= hit_nxt;
      busy_r  <= busy_nxt;
    end
    if (ctl.load) begin
      tx_r <= prv_tx; ty_r <= prv_ty; bx_r <= prv_bx; by_r <= prv_by;
      cx_r <= prv_tx; cy_r <= prv_ty; err_r <= '0;
    end else begin
      err_r <= err_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt; oldy_r <= oldy_nxt;
    end
  end

  assign valid = valid_r;
  assign tx = tx_r; assign ty = ty_r; assign bx = bx_r; assign by = by_r;
  assign hit = hit_r & valid_r;
  assign busy = busy_r;
  assign cur_x = cx_r;
endmodule

// ===== hdl/polygon_scanline_fill.sv =====
// polygon_scanline_fill: top level, vertex store, edge build, sort and span output.
// Depends on psf_pkg and psf_edge_cell.
//
// channel  direction  handshake              payload
// in_      input      in_valid / in_stall    in_opcode, in_vertex_x, in_vertex_y
// out_     output     out_valid / out_stall  out_row ... out_vertex_overflow
// cfg_     input      cfg_we                 cfg_wdata (span color)
//
// Clear/add/nop: the next transaction is taken at the edge that hands on the result.
// A row request: edge build (first request after a change), an enter state,
// Bresenham steps until the slowest edge is done (cells step in parallel, a guard
// bounds the steps), a sort over all MAX_EDGES cells, a setup state, then one span
// per cycle while the output is not stalled. rst_n is synchronous.
// out_stall holds the result register; one item is in flight at a time.
module polygon_scanline_fill import psf_pkg::*; #(
  parameter int MAX_EDGES  = 16,
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [COORD_BITS-1:0] in_vertex_x,
  input  logic [COORD_BITS-1:0] in_vertex_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_row,
  output logic [OUT_W-1:0]      out_x_start,
  output logic [OUT_W-1:0]      out_x_end,
  output logic [COLOR_W-1:0]    out_color_out,
  output logic                  out_span_valid,
  output logic                  out_last_of_row,
  output logic                  out_fill_done,
  output logic                  out_vertex_overflow,
  input  logic                  cfg_we,
  input  logic [COLOR_W-1:0]    cfg_wdata
);
  localparam int CW  = COORD_BITS;
  localparam int EI  = $clog2(MAX_EDGES);
  localparam int VC  = $clog2(MAX_EDGES + 1);
  localparam int SC  = $clog2(MAX_SPANS + 1);
  localparam int GC  = $clog2(2 * (1 << CW) + 6);
  localparam int GUARD = 2 * ((1 << CW) - 1) + 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BUILD = 3'd1;
  localparam logic [2:0] S_ENTER = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_SORT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]          state_r;
  logic [COLOR_W-1:0]  color_r;
  logic [CW-1:0]       vx_mem [MAX_EDGES];
  logic [CW-1:0]       vy_mem [MAX_EDGES];
  logic [VC-1:0]       vcnt_r;
  logic                built_r;
  logic [CW:0]         cur_row_r;
  logic [CW-1:0]       low_row_r, hi_r;
  logic [VC-1:0]       bi_r;
  logic [CW-1:0]       first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [GC-1:0]       guard_r;
  logic [EI:0]         sidx_r, nx_r;
  logic [CW-1:0]       xs_r [MAX_EDGES];
  logic [SC-1:0]       k_r;
  logic                done_r;
  logic [CW-1:0]       row_r;

  // output register
  logic                ov_r;
  logic [OUT_W-1:0]    o_row_r, o_xs_r, o_xe_r;
  logic [COLOR_W-1:0]  o_col_r;
  logic                o_sv_r, o_last_r, o_done_r, o_ovf_r;

  cell_ctl_t           ctl;
  logic [CW-1:0]       ld_tx, ld_ty, ld_bx, ld_by;
  logic                ld_valid;
  logic [MAX_EDGES:0]  c_valid;
  logic [CW-1:0]       c_tx [MAX_EDGES+1];
  logic [CW-1:0]       c_ty [MAX_EDGES+1];
  logic [CW-1:0]       c_bx [MAX_EDGES+1];
  logic [CW-1:0]       c_by [MAX_EDGES+1];
  logic [MAX_EDGES-1:0] c_hit, c_busy;
  logic [CW-1:0]       c_x [MAX_EDGES];

  assign c_valid[0] = ld_valid;
  assign c_tx[0] = ld_tx; assign c_ty[0] = ld_ty;
  assign c_bx[0] = ld_bx; assign c_by[0] = ld_by;

  for (genvar g = 0; g < MAX_EDGES; g++) begin : g_cell
    psf_edge_cell #(.CW(CW)) u_cell (
      .clk, .rst_n, .ctl, .row(row_r),
      .prv_valid(c_valid[g]), .prv_tx(c_tx[g]), .prv_ty(c_ty[g]),
      .prv_bx(c_bx[g]), .prv_by(c_by[g]),
      .valid(c_valid[g+1]), .tx(c_tx[g+1]), .ty(c_ty[g+1]),
      .bx(c_bx[g+1]), .by(c_by[g+1]),
      .hit(c_hit[g]), .busy(c_busy[g]), .cur_x(c_x[g])
    );
  end

  // build: side from previous vertex to current one (closing side last)
  logic          b_last;
  logic [CW-1:0] bx_a, by_a, bx_b, by_b;
  logic          b_side;
  always_comb begin
    b_last = (bi_r == vcnt_r);
    bx_a = prev_x_r; by_a = prev_y_r;
    bx_b = b_last ? first_x_r : vx_mem[bi_r[EI-1:0]];
    by_b = b_last ? first_y_r : vy_mem[bi_r[EI-1:0]];
    b_side = (bi_r != '0) && (by_a != by_b);
    ld_valid = 1'b1;
    ld_tx = (by_a > by_b) ? bx_a : bx_b;
    ld_ty = (by_a > by_b) ? by_a : by_b;
    ld_bx = (by_a > by_b) ? bx_b : bx_a;
    ld_by = (by_a > by_b) ? by_b : by_a;
  end

  // edges are loaded in reverse, so crossings arrive reversed; sort is stable
  // on equal x, equal values are interchangeable
  logic sort_take;
  logic [EI-1:0] sel;
  assign sel = sidx_r[EI-1:0];
  assign sort_take = c_hit[sel];

  logic in_acc, out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    ctl = '0;
    if (in_acc && (in_opcode == OP_CLEAR || in_opcode == OP_ADD)) ctl.clr = 1'b1;
    if (state_r == S_BUILD && bi_r == '0) ctl.clr = 1'b1;
    if (state_r == S_BUILD && b_side) ctl.load = 1'b1;
    if (state_r == S_ENTER) ctl.enter = 1'b1;
    if (state_r == S_STEP) ctl.step = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_opcode == OP_ADD && vcnt_r < VC'(MAX_EDGES)) begin
      vx_mem[vcnt_r[EI-1:0]] <= in_vertex_x;
      vy_mem[vcnt_r[EI-1:0]] <= in_vertex_y;
    end
    if (!rst_n) begin
      color_r   <= '0;
      state_r   <= S_IDLE;
      vcnt_r    <= '0;
      built_r   <= 1'b0;
      cur_row_r <= '0;
      low_row_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we) color_r <= cfg_wdata;
      // a new result is loaded by the IDLE accept and in S_BUILD, S_EMIT and S_OUT
      if (ov_r && !out_stall && !in_acc && state_r != S_OUT) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          o_row_r <= '0; o_xs_r <= '0; o_xe_r <= '0; o_col_r <= '0;
          o_sv_r <= 1'b0; o_last_r <= 1'b1;
          unique case (in_opcode)
            OP_CLEAR: begin
              vcnt_r <= '0; built_r <= 1'b0; cur_row_r <= '0; low_row_r <= '0;
              ov_r <= 1'b1; o_done_r <= 1'b1; o_ovf_r <= 1'b0;
            end
            OP_ADD: begin
              built_r <= 1'b0;
              ov_r <= 1'b1; o_done_r <= 1'b0;
              if (vcnt_r < VC'(MAX_EDGES)) begin
                vcnt_r <= vcnt_r + 1'b1;
                o_ovf_r <= 1'b0;
              end else o_ovf_r <= 1'b1;
            end
            OP_ROW: begin
              ov_r <= built_r && (cur_row_r <= {1'b0, low_row_r});
              o_done_r <= 1'b1; o_ovf_r <= 1'b0;
              bi_r <= '0;
              row_r <= cur_row_r[CW-1:0];
              if (!built_r) state_r <= S_BUILD;
              else if (cur_row_r <= {1'b0, low_row_r}) state_r <= S_IDLE;
              else state_r <= S_ENTER;
            end
            default: begin
              ov_r <= 1'b1; o_done_r <= 1'b0; o_ovf_r <= 1'b0;
            end
          endcase
        end
        S_BUILD: begin
          if (bi_r == '0) begin
            cur_row_r <= '0; built_r <= 1'b1;
            if (vcnt_r == '0) begin
              low_row_r <= '0;
              ov_r <= 1'b1; o_done_r <= 1'b1; state_r <= S_IDLE;
            end else begin
              first_x_r <= vx_mem[0]; first_y_r <= vy_mem[0];
              prev_x_r <= vx_mem[0]; prev_y_r <= vy_mem[0];
              hi_r <= vy_mem[0]; low_row_r <= vy_mem[0];
              bi_r <= VC'(1);
            end
          end else if (b_last) begin
            cur_row_r <= {1'b0, hi_r};
            row_r <= hi_r;
            if (hi_r <= low_row_r) begin
              ov_r <= 1'b1; o_done_r <= 1'b1; state_r <= S_IDLE;
            end else state_r <= S_ENTER;
          end else begin
            prev_x_r <= bx_b; prev_y_r <= by_b;
            if (by_b > hi_r) hi_r <= by_b;
            if (by_b < low_row_r) low_row_r <= by_b;
            bi_r <= bi_r + 1'b1;
          end
        end
        S_ENTER: begin
          guard_r <= '0;
          state_r <= S_STEP;
        end
        S_STEP: begin
          guard_r <= guard_r + 1'b1;
          if (c_busy == '0 || guard_r == GC'(GUARD)) begin
            state_r <= S_SORT; sidx_r <= '0; nx_r <= '0;
          end
        end
        S_SORT: begin
          if (sort_take) begin
            for (int p = 0; p < MAX_EDGES; p++) begin
              if (EI'(p) == nx_r[EI-1:0] || (p < nx_r && xs_r[p] > c_x[sel]))
                begin
                if (p == 0 ||
                    !(p < nx_r + 1 && p > 0 && xs_r[(p > 0) ? p - 1 : 0] > c_x[sel]))
                  xs_r[p] <= c_x[sel];
                else xs_r[p] <= xs_r[(p > 0) ? p - 1 : 0];
              end
            end
            nx_r <= nx_r + 1'b1;
          end
          sidx_r <= sidx_r + 1'b1;
          if (sidx_r == (EI+1)'(MAX_EDGES - 1)) begin
            state_r <= S_EMIT; k_r <= '0;
            cur_row_r <= cur_row_r - 1'b1;
            done_r <= (cur_row_r - 1'b1) <= {1'b0, low_row_r};
          end
        end
        S_EMIT: begin
          o_row_r <= OUT_W'(row_r); o_ovf_r <= 1'b0;
          o_done_r <= done_r;
          if (nx_r < 2) begin
            ov_r <= 1'b1; o_xs_r <= '0; o_xe_r <= '0; o_col_r <= '0;
            o_sv_r <= 1'b0; o_last_r <= 1'b1; state_r <= S_IDLE;
          end else state_r <= S_OUT;
        end
        S_OUT: if (out_free) begin
          ov_r <= 1'b1;
          o_xs_r <= OUT_W'(xs_r[EI'({k_r, 1'b0})]);
          o_xe_r <= OUT_W'(xs_r[EI'({k_r, 1'b1})]);
          o_col_r <= color_r; o_sv_r <= 1'b1;
          k_r <= k_r + 1'b1;
          if ((EI+2)'(2*k_r + 4) > (EI+2)'(nx_r) || k_r == SC'(MAX_SPANS - 1)) begin
            o_last_r <= 1'b1; state_r <= S_IDLE;
          end else o_last_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_row = o_row_r;
  assign out_x_start = o_xs_r;
  assign out_x_end = o_xe_r;
  assign out_color_out = o_col_r;
  assign out_span_valid = o_sv_r;
  assign out_last_of_row = o_last_r;
  assign out_fill_done = o_done_r;
  assign out_vertex_overflow = o_ovf_r;
endmodule
